// ----- src/curve_midline_fill_assert.svh -----
// Assertion macros for the curve midline fill block.
// Used by the port checker; no other dependencies.
`ifndef CURVE_MIDLINE_FILL_ASSERT_SVH
`define CURVE_MIDLINE_FILL_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CMF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cmf_pkg.sv -----
// Package for the curve midline fill block: field widths, constants,
// mode codes and item/state structs. No dependencies.
`default_nettype none

package cmf_pkg;

    localparam int ROW_W  = 7;
    localparam int COL_W  = 8;
    localparam int MID_W  = 10;
    localparam int MODE_W = 3;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    localparam logic [COL_W-1:0] LAST_COL     = 8'd159;
    localparam logic [ROW_W-1:0] ROW_FILL_MAX = 7'd118;
    localparam logic [COL_W-1:0] OFFSET_RESET = 8'd80;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE        = 3'd0,
        MODE_SMALL_RIGHT = 3'd1,
        MODE_SMALL_LEFT  = 3'd2,
        MODE_LARGE_RIGHT = 3'd3,
        MODE_LARGE_LEFT  = 3'd4
    } mode_t;

    // first field in the highest bits
    typedef struct packed {
        logic [ROW_W-1:0]         top_row;
        logic [ROW_W-1:0]         fill_start_row;
        logic [MODE_W-1:0]        turn_mode;
        logic signed [MID_W-1:0]  mid_in;
        logic [COL_W-1:0]         right_edge;
        logic [COL_W-1:0]         left_edge;
        logic [ROW_W-1:0]         row;
    } item_t;

    typedef struct packed {
        logic signed [MID_W-1:0]  mid;
        logic [COL_W-1:0]         left;
        logic [COL_W-1:0]         right;
    } prev_t;

endpackage

`default_nettype wire

// ----- src/curve_midline_fill.sv -----
// Curve midline fill, top level: input register, fill core, result register,
// previous-row state and the offset register. Depends on cmf_pkg, cmf_fill_core.
//
// Usage:
//   s_ channel: one item per image row, bottom row first. An item is taken
//   when s_tvalid and s_tready are both high.
//   m_ channel: one result per item, in order, held while m_tready is low.
//   cfg channel: writes half_track_offset (always ready); write only when idle.
//   Path: an accepted item passes the input register, then the fill logic
//   into the result register, before m_tvalid rises.
//   Throughput: one item per cycle while m_tready is high; the input register
//   drains into the result register whenever that is empty or being taken.
//   Previous row's midline and edges update as an item moves into the result
//   register, so the next item in the input register sees the new values.
//   Stall: with m_tready low both registers fill, then s_tready drops; no item
//   is lost or repeated.
//   Reset (aresetn low, synchronous): both registers empty, previous-row state
//   zero, half_track_offset back to 80.
`default_nettype none

module curve_midline_fill import cmf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row[6:0], left_edge[14:7], right_edge[22:15], mid_in[32:23],
    // turn_mode[35:33], fill_start_row[42:36], top_row[49:43], unused[55:50]
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // row_out[6:0], mid_out[16:7], zero[23:17]
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [COL_W-1:0]     cfg_data
);

    logic                    in_valid_reg;
    item_t                   in_item_reg;
    logic                    out_valid_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic signed [MID_W-1:0] out_mid_reg;
    prev_t                   prev_reg;
    prev_t                   prev_next;
    logic [COL_W-1:0]        offset_reg;
    logic signed [MID_W-1:0] fill_mid;
    logic                    advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    cmf_fill_core u_core (
        .item              (in_item_reg),
        .prev              (prev_reg),
        .half_track_offset (offset_reg),
        .mid_out           (fill_mid)
    );

    always_comb begin
        prev_next.mid   = fill_mid;
        prev_next.left  = in_item_reg.left_edge;
        prev_next.right = in_item_reg.right_edge;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            offset_reg    <= OFFSET_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                prev_reg      <= prev_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                offset_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (advance) begin
            out_row_reg <= in_item_reg.row;
            out_mid_reg <= fill_mid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-ROW_W-MID_W){1'b0}}, out_mid_reg, out_row_reg};

endmodule

`default_nettype wire

// ----- src/cmf_fill_core.sv -----
// Midline fill arithmetic for one row: window test, per-mode value and clamps.
// Depends on cmf_pkg.
`default_nettype none

module cmf_fill_core import cmf_pkg::*; (
    input  item_t                   item,
    input  prev_t                   prev,
    input  logic [COL_W-1:0]        half_track_offset,
    output logic signed [MID_W-1:0] mid_out
);

    logic                 small_win;
    logic                 large_win;
    logic signed [11:0]   prev_mid_x;
    logic signed [11:0]   right_x;
    logic signed [11:0]   left_x;
    logic signed [11:0]   prev_right_x;
    logic signed [11:0]   prev_left_x;
    logic signed [11:0]   off_x;
    logic signed [11:0]   m1;
    logic signed [11:0]   m2;
    logic signed [11:0]   m3;
    logic signed [11:0]   m4;
    logic signed [11:0]   last_x;

    assign small_win = (item.row > item.top_row) && (item.row <= item.fill_start_row);
    assign large_win = (item.row > item.top_row) && (item.row <= ROW_FILL_MAX);

    assign prev_mid_x   = {{2{prev.mid[MID_W-1]}}, prev.mid};
    assign right_x      = $signed({4'b0, item.right_edge});
    assign left_x       = $signed({4'b0, item.left_edge});
    assign prev_right_x = $signed({4'b0, prev.right});
    assign prev_left_x  = $signed({4'b0, prev.left});
    assign off_x        = $signed({4'b0, half_track_offset});
    assign last_x       = $signed({4'b0, LAST_COL});

    assign m1 = (item.right_edge == LAST_COL) ? prev_mid_x - 12'sd1
                                              : prev_mid_x - prev_right_x + right_x;
    assign m2 = (item.left_edge == '0) ? prev_mid_x + 12'sd1
                                       : prev_mid_x - left_x + prev_left_x;
    assign m3 = right_x - off_x;
    assign m4 = left_x + off_x;

    always_comb begin
        mid_out = item.mid_in;
        case (mode_t'(item.turn_mode))
            MODE_SMALL_RIGHT: begin
                if (small_win) begin
                    if (m1 <= 12'sd0) begin
                        mid_out = '0;
                    end else if (m1 > 12'sd511) begin
                        mid_out = 10'sd511;
                    end else begin
                        mid_out = m1[MID_W-1:0];
                    end
                end
            end
            MODE_SMALL_LEFT: begin
                if (small_win) begin
                    if (m2 >= last_x) begin
                        mid_out = last_x[MID_W-1:0];
                    end else if (m2 < -12'sd512) begin
                        mid_out = -10'sd512;
                    end else begin
                        mid_out = m2[MID_W-1:0];
                    end
                end
            end
            MODE_LARGE_RIGHT: begin
                if (large_win) begin
                    mid_out = (m3 <= 12'sd0) ? '0 : m3[MID_W-1:0];
                end
            end
            MODE_LARGE_LEFT: begin
                if (large_win) begin
                    mid_out = (m4 >= last_x) ? last_x[MID_W-1:0] : m4[MID_W-1:0];
                end
            end
            default: begin
                mid_out = item.mid_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/cmf_checker.sv -----
// Port-level checker for curve_midline_fill, bound to the top level.
// Depends on cmf_pkg and curve_midline_fill_assert.svh.
`default_nettype none

`include "curve_midline_fill_assert.svh"

module cmf_checker import cmf_pkg::*; (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire [S_DATA_W-1:0]  s_tdata,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_DATA_W-1:0]  m_tdata
);

    logic in_busy;

    assign in_busy = s_tvalid;

    // a stalled result holds
    `CMF_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    // input back-pressure only when a result is waiting and stalled
    `CMF_ASSERT_NOW(a_stall_cause, aclk, aresetn,
        in_busy && !s_tready, m_tvalid && !m_tready,
        "input stalled without output stall")

    // no result straight after reset
    `CMF_ASSERT_NOW(a_reset_empty, aclk, aresetn,
        $past(!aresetn), !m_tvalid,
        "result present after reset")

endmodule

bind curve_midline_fill cmf_checker u_cmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
